// ===== design/hog_pkg.sv =====
// ----------------------------------------------------------------------------
// HOG cell histogram package
// Shared widths, constants, the square root status type, the absolute difference and the bin selector.
// ----------------------------------------------------------------------------
package hog_pkg;

  localparam int unsigned PIX_W    = 8;
  localparam int unsigned DIFF_W   = PIX_W + 1;
  localparam int unsigned NUM_BINS = 9;
  localparam int unsigned BIN_W    = 4;
  localparam int unsigned SUM_W    = 19;
  localparam int unsigned MAG_W    = 13;
  localparam int unsigned RAD_W    = 2 * MAG_W;
  localparam int unsigned PROD_W   = 43;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  localparam logic [BIN_W-1:0] BIN_HORIZONTAL = 4'd0;
  localparam logic [BIN_W-1:0] BIN_VERTICAL   = 4'd4;
  localparam logic [BIN_W-1:0] BIN_LAST       = 4'd8;

  // Tangents of 20, 40 and 80 degrees in Q32.
  localparam logic [PROD_W-1:0] TAN20_Q32 = 43'd1563240253;
  localparam logic [PROD_W-1:0] TAN40_Q32 = 43'd3603905474;
  localparam logic [PROD_W-1:0] TAN80_Q32 = 43'd24357969942;

  typedef struct packed {
    logic             done;
    logic [MAG_W-1:0] root;
  } sqrt_stat_t;

  function automatic logic [PIX_W-1:0] abs_diff(input logic [DIFF_W-1:0] d);
    abs_diff = d[DIFF_W-1] ? PIX_W'(~d + 9'd1) : d[PIX_W-1:0];
  endfunction

  // Nine 20-degree bins over [0,180). The angle band is counted from the
  // x axis by comparing |gy| against |gx| times each tangent (squares at 60).
  function automatic logic [BIN_W-1:0] pick_bin(input logic [DIFF_W-1:0] gx,
                                                input logic [DIFF_W-1:0] gy);
    logic [PIX_W-1:0]   ax;
    logic [PIX_W-1:0]   ay;
    logic [PROD_W-1:0]  lhs;
    logic [2*PIX_W-1:0] ay2;
    logic [2*PIX_W+1:0] ax2x3;
    logic [2:0]         cnt;
    ax    = abs_diff(gx);
    ay    = abs_diff(gy);
    lhs   = {3'd0, ay, 32'd0};
    ay2   = ay * ay;
    ax2x3 = 18'd3 * (18'(ax) * 18'(ax));
    cnt   = 3'(lhs >= PROD_W'(ax) * TAN20_Q32)
          + 3'(lhs >= PROD_W'(ax) * TAN40_Q32)
          + 3'(18'(ay2) >= ax2x3)
          + 3'(lhs >= PROD_W'(ax) * TAN80_Q32);
    if (gx == '0) begin
      pick_bin = BIN_VERTICAL;
    end else if (gy == '0) begin
      pick_bin = BIN_HORIZONTAL;
    end else if (gx[DIFF_W-1] == gy[DIFF_W-1]) begin
      pick_bin = BIN_W'(cnt);
    end else begin
      pick_bin = BIN_LAST - BIN_W'(cnt);
    end
  endfunction

endpackage

// ===== design/hog_isqrt.sv =====
// ----------------------------------------------------------------------------
// HOG integer square root
// Restoring digit-by-digit square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module hog_isqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [hog_pkg::RAD_W-1:0]   radicand,
  output hog_pkg::sqrt_stat_t         stat
);

  localparam int unsigned REM_W = hog_pkg::MAG_W + 1;
  localparam int unsigned CNT_W = $clog2(hog_pkg::MAG_W);

  logic [hog_pkg::RAD_W-1:0] rad_r,  rad_nxt;
  logic [REM_W-1:0]          rem_r,  rem_nxt;
  logic [hog_pkg::MAG_W-1:0] root_r, root_nxt;
  logic [CNT_W-1:0]          cnt_r,  cnt_nxt;
  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;

  logic [REM_W+1:0] rem2;
  logic [REM_W+1:0] trial;

  always_comb begin
    rem2     = {rem_r, rad_r[hog_pkg::RAD_W-1 -: 2]};
    trial    = {1'b0, root_r, 2'b01};
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt = {rad_r[hog_pkg::RAD_W-3:0], 2'b00};
      if (rem2 >= trial) begin
        rem_nxt  = REM_W'(rem2 - trial);
        root_nxt = {root_r[hog_pkg::MAG_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem2[REM_W-1:0];
        root_nxt = {root_r[hog_pkg::MAG_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(hog_pkg::MAG_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign stat.done = done_r;
  assign stat.root = root_r;

endmodule

// ===== design/hog_cell_orientation_histogram_unit.sv =====
// ----------------------------------------------------------------------------
// HOG cell orientation histogram unit
// Accumulates gradient magnitudes of a cell's pixels into nine orientation
// bins held in a small memory and emits the bins on the cell's last pixel.
// ----------------------------------------------------------------------------
//   Port group | Direction | Payload
//   in_*       | slave     | four neighbor pixels, in_tlast = cell end
//   out_*      | master    | nine 19-bit bin sums
//
// Each pixel is accepted, then its energy and bin are formed, its root is taken
// bit-serially, and its bin entry is read-modified-written; only then is the
// next pixel accepted. On a cell end the unit waits for the output register to
// be free, reads and clears the nine bin entries in turn, and finishes the result.
// A held result in the output register stalls only the next cell's readout.
// Reset is synchronous; the bin memory reads as zero after it.
module hog_cell_orientation_histogram_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [31:0]   in_tdata,   // left_pixel, right_pixel, up_pixel, down_pixel
  input  logic          in_tlast,   // cell_end
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [175:0]  out_tdata   // bin_0 .. bin_8, 19 bits each, zero filled
);

  localparam int unsigned PW = hog_pkg::PIX_W;
  localparam int unsigned DW = hog_pkg::DIFF_W;
  localparam int unsigned SW = hog_pkg::SUM_W;
  localparam int unsigned BW = hog_pkg::BIN_W;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_PREP  = 6'b000010,
    ST_SQRT  = 6'b000100,
    ST_DRAIN = 6'b001000,
    ST_SWEEP = 6'b010000,
    ST_FLUSH = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [DW-1:0] gx_r, gx_nxt;
  logic [DW-1:0] gy_r, gy_nxt;
  logic          last_r, last_nxt;
  logic [BW-1:0] bin_r, bin_nxt;
  logic [BW-1:0] idx_r, idx_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          cap_en_r;
  logic [BW-1:0] cap_idx_r;

  logic [SW-1:0] bin_mem [hog_pkg::NUM_BINS];
  logic [hog_pkg::NUM_BINS-1:0] vld_r;
  logic [SW-1:0] rd_data_r;
  logic [SW-1:0] out_bin_r [hog_pkg::NUM_BINS];

  logic [BW-1:0] rd_addr;
  logic          acc_we;
  logic          sweep_clr;
  logic [SW:0]   sum_wide;
  logic [SW-1:0] sum_sat;

  logic                       sqrt_start;
  logic [hog_pkg::RAD_W-1:0]  radicand;
  logic [PW-1:0]              ax, ay;
  logic [2*PW:0]              energy;
  hog_pkg::sqrt_stat_t        sqrt_stat;

  logic out_free;

  assign out_free = !out_valid_r || out_tready;

  assign ax       = hog_pkg::abs_diff(gx_r);
  assign ay       = hog_pkg::abs_diff(gy_r);
  assign energy   = (2*PW+1)'(ax * ax) + (2*PW+1)'(ay * ay);
  assign radicand = hog_pkg::RAD_W'({energy, 8'd0});

  assign sum_wide = {1'b0, rd_data_r} + (SW+1)'(sqrt_stat.root);
  assign sum_sat  = sum_wide[SW] ? hog_pkg::SUM_MAX : sum_wide[SW-1:0];

  hog_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (radicand),
    .stat     (sqrt_stat)
  );

  always_comb begin
    state_nxt     = state_r;
    gx_nxt        = gx_r;
    gy_nxt        = gy_r;
    last_nxt      = last_r;
    bin_nxt       = bin_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    in_tready     = 1'b0;
    sqrt_start    = 1'b0;
    acc_we        = 1'b0;
    sweep_clr     = 1'b0;
    rd_addr       = bin_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          gx_nxt    = DW'(in_tdata[15:8]) - DW'(in_tdata[7:0]);
          gy_nxt    = DW'(in_tdata[31:24]) - DW'(in_tdata[23:16]);
          last_nxt  = in_tlast;
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        sqrt_start = 1'b1;
        bin_nxt    = hog_pkg::pick_bin(gx_r, gy_r);
        state_nxt  = ST_SQRT;
      end
      ST_SQRT: begin
        // The bin entry is read during the root iterations; nothing else
        // writes the memory meanwhile, so the registered read stays current.
        if (sqrt_stat.done) begin
          acc_we    = 1'b1;
          state_nxt = last_r ? ST_DRAIN : ST_IDLE;
        end
      end
      ST_DRAIN: begin
        idx_nxt = '0;
        if (out_free) begin
          state_nxt = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        rd_addr   = idx_r;
        sweep_clr = 1'b1;
        idx_nxt   = idx_r + 1'b1;
        if (idx_r == hog_pkg::BIN_LAST) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
      cap_en_r    <= 1'b0;
      last_r      <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cap_en_r    <= sweep_clr;
      last_r      <= last_nxt;
      idx_r       <= idx_nxt;
      if (acc_we) begin
        vld_r[bin_r] <= 1'b1;
      end else if (sweep_clr) begin
        vld_r[idx_r] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    gx_r      <= gx_nxt;
    gy_r      <= gy_nxt;
    bin_r     <= bin_nxt;
    cap_idx_r <= idx_r;
    if (cap_en_r) begin
      out_bin_r[cap_idx_r] <= rd_data_r;
    end
  end

  // Bin memory: one write port, one registered read port. An entry whose
  // valid bit is clear reads as zero.
  always_ff @(posedge clk) begin
    if (acc_we) begin
      bin_mem[bin_r] <= sum_sat;
    end
    rd_data_r <= vld_r[rd_addr] ? bin_mem[rd_addr] : '0;
  end

  always_comb begin
    out_tdata = '0;
    for (int k = 0; k < hog_pkg::NUM_BINS; k++) begin
      out_tdata[k*SW +: SW] = out_bin_r[k];
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

// ===== design/hog_checker.sv =====
// ----------------------------------------------------------------------------
// HOG cell histogram port checker
// Watches the top level's ports and flags handshake and sequencing errors.
// ----------------------------------------------------------------------------
module hog_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_tvalid,
  input logic          in_tready,
  input logic          in_tlast,
  input logic          out_tvalid,
  input logic          out_tready,
  input logic [175:0]  out_tdata
);

  // A stalled result stays offered.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its bins.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");

  // Each pixel is worked on alone, so the input closes after an accept.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("item accepted while another is in flight");

  // A new result appears only out of the readout, when the input is closed.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result raised outside the bin readout");

  // A pixel accepted without cell end shows no result when it reaches the square root state.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tlast && !out_tvalid |=> ##1 !out_tvalid)
    else $error("result raised by a pixel inside the cell");

endmodule

bind hog_cell_orientation_histogram_unit hog_checker u_hog_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
